// ===== design/first_fit_block_allocator_assert.svh =====
// assertion macros for the first-fit block allocator
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH

// condition holds at every clock edge out of reset
`define FFA_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define FFA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/ffa_pkg.sv =====
// package: constants and types of the first-fit block allocator
`default_nettype none
package ffa_pkg;

  localparam int HEAP_BYTES   = 65536;
  localparam int HEADER_BYTES = 12;
  localparam int MAX_BLOCKS   = 64;
  localparam int SPLIT_SLACK  = 16;

  localparam int AW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);

  localparam logic [16:0]   HDR17     = 17'(HEADER_BYTES);
  localparam logic [17:0]   SPLIT18   = 18'(HEADER_BYTES + SPLIT_SLACK);
  localparam logic [15:0]   INIT_LEN  = 16'(HEAP_BYTES - HEADER_BYTES);
  localparam logic [CW-1:0] MAX_CNT   = CW'(MAX_BLOCKS);

  localparam logic       OP_ALLOC = 1'b0;
  localparam logic       OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;
  localparam logic [1:0] ST_UNKNOWN = 2'd3;

  typedef struct packed {
    logic        operation;
    logic [15:0] request_size;
    logic [15:0] release_offset;
  } ffa_req_t;

  typedef struct packed {
    logic [15:0] payload_offset;
    logic [1:0]  status;
    logic [16:0] used_bytes;
  } ffa_rsp_t;

  typedef struct packed {
    logic [15:0] start;
    logic [15:0] len;
    logic        free;
  } ffa_entry_t;

  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    ffa_entry_t    wdata;
    logic [AW-1:0] raddr;
  } ffa_mem_req_t;

endpackage
`default_nettype wire

// ===== design/ffa_mem.sv =====
// block table memory: one write port, one registered read port
`default_nettype none
module ffa_mem (
  input  wire                   clk_i,
  input  ffa_pkg::ffa_mem_req_t req_i,
  output ffa_pkg::ffa_entry_t   rdata_o
);
  import ffa_pkg::*;

  ffa_entry_t mem_q [MAX_BLOCKS];
  ffa_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem_q[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== design/ffa_ctrl.sv =====
// sequencer: first-fit scan, split insert, free and merge over the table
`default_nettype none
module ffa_ctrl (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_ready_o,
  input  ffa_pkg::ffa_req_t     in_data_i,
  output logic                  out_valid_o,
  input  wire                   out_ready_i,
  output ffa_pkg::ffa_rsp_t     out_data_o,
  output ffa_pkg::ffa_mem_req_t mem_o,
  input  ffa_pkg::ffa_entry_t   mem_rdata_i
);
  import ffa_pkg::*;

  localparam logic [4:0] S_INIT     = 5'd0;
  localparam logic [4:0] S_IDLE     = 5'd1;
  localparam logic [4:0] S_SCAN_RD  = 5'd2;
  localparam logic [4:0] S_SCAN_CK  = 5'd3;
  localparam logic [4:0] S_INS_RD   = 5'd4;
  localparam logic [4:0] S_INS_WR   = 5'd5;
  localparam logic [4:0] S_INS_FIN  = 5'd6;
  localparam logic [4:0] S_ALLOC_WR = 5'd7;
  localparam logic [4:0] S_PREV_RD  = 5'd8;
  localparam logic [4:0] S_PREV_CK  = 5'd9;
  localparam logic [4:0] S_NEXT_RD  = 5'd10;
  localparam logic [4:0] S_NEXT_CK  = 5'd11;
  localparam logic [4:0] S_MERGE    = 5'd12;
  localparam logic [4:0] S_RM_CHK   = 5'd13;
  localparam logic [4:0] S_RM_RD    = 5'd14;
  localparam logic [4:0] S_RM_WR    = 5'd15;
  localparam logic [4:0] S_RESP     = 5'd16;

  logic [4:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [16:0]   used_q, used_d;
  logic          out_valid_q, out_valid_d;
  ffa_rsp_t      out_q, out_d;

  logic          op_q, op_d;
  logic [16:0]   sz_q, sz_d;
  logic [15:0]   off_q, off_d;
  logic [CW-1:0] k_q, k_d;
  logic [CW-1:0] hit_q, hit_d;
  ffa_entry_t    cur_q, cur_d;
  ffa_entry_t    prev_q, prev_d;
  ffa_entry_t    next_q, next_d;
  logic [1:0]    rm_n_q, rm_n_d;
  logic [15:0]   res_off_q, res_off_d;
  logic [1:0]    res_st_q, res_st_d;

  logic [CW-1:0] k_inc, k_dec, hit_inc;
  logic [CW:0]   k_plus_n;
  logic          has_next;
  logic [16:0]   amount;
  logic [16:0]   e_off17;
  logic          split;

  assign k_inc    = k_q + CW'(1);
  assign k_dec    = k_q - CW'(1);
  assign hit_inc  = hit_q + CW'(1);
  assign k_plus_n = {1'b0, k_q} + (CW+1)'(rm_n_q);
  assign has_next = ({1'b0, hit_q} + (CW+1)'(1)) < {1'b0, cnt_q};
  assign amount   = HDR17 + {1'b0, cur_q.len};
  assign e_off17  = {1'b0, mem_rdata_i.start} + HDR17;
  assign split    = ({2'b0, mem_rdata_i.len} > ({1'b0, sz_q} + SPLIT18)) && (cnt_q < MAX_CNT);

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    used_d      = used_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    op_d        = op_q;
    sz_d        = sz_q;
    off_d       = off_q;
    k_d         = k_q;
    hit_d       = hit_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    next_d      = next_q;
    rm_n_d      = rm_n_q;
    res_off_d   = res_off_q;
    res_st_d    = res_st_q;
    mem_o       = '0;
    mem_o.raddr = k_q[AW-1:0];

    case (state_q)
      S_INIT: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = '0;
        mem_o.wdata = '{start: 16'd0, len: INIT_LEN, free: 1'b1};
        state_d     = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          op_d      = in_data_i.operation;
          sz_d      = ({1'b0, in_data_i.request_size} + 17'd7) & ~17'd7;
          off_d     = in_data_i.release_offset;
          k_d       = '0;
          res_off_d = '0;
          state_d   = S_SCAN_RD;
          if (in_data_i.operation == OP_ALLOC && in_data_i.request_size == 16'd0) begin
            res_st_d = ST_NOFIT;
            state_d  = S_RESP;
          end else if (in_data_i.operation == OP_FREE && in_data_i.release_offset == 16'd0) begin
            res_st_d = ST_IGNORED;
            state_d  = S_RESP;
          end
        end
      end
      S_SCAN_RD: begin
        mem_o.raddr = k_q[AW-1:0];
        state_d     = S_SCAN_CK;
      end
      S_SCAN_CK: begin
        if (op_q == OP_ALLOC) begin
          if (mem_rdata_i.free && ({1'b0, mem_rdata_i.len} >= sz_q)) begin
            hit_d    = k_q;
            cur_d    = mem_rdata_i;
            res_st_d = ST_OK;
            if (split) begin
              k_d = cnt_q;
              if (cnt_q > k_q + CW'(1)) begin
                state_d = S_INS_RD;
              end else begin
                state_d = S_INS_FIN;
              end
            end else begin
              state_d = S_ALLOC_WR;
            end
          end else begin
            k_d = k_inc;
            if (k_inc == cnt_q) begin
              res_st_d = ST_NOFIT;
              state_d  = S_RESP;
            end else begin
              state_d = S_SCAN_RD;
            end
          end
        end else begin
          if (e_off17 == {1'b0, off_q}) begin
            hit_d = k_q;
            cur_d = mem_rdata_i;
            if (mem_rdata_i.free) begin
              res_st_d = ST_IGNORED;
              state_d  = S_RESP;
            end else begin
              res_st_d = ST_OK;
              state_d  = S_PREV_RD;
            end
          end else begin
            k_d = k_inc;
            if (k_inc == cnt_q) begin
              res_st_d = ST_UNKNOWN;
              state_d  = S_RESP;
            end else begin
              state_d = S_SCAN_RD;
            end
          end
        end
      end
      S_INS_RD: begin
        mem_o.raddr = k_dec[AW-1:0];
        state_d     = S_INS_WR;
      end
      S_INS_WR: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = k_q[AW-1:0];
        mem_o.wdata = mem_rdata_i;
        k_d         = k_dec;
        if (k_dec > hit_inc) begin
          state_d = S_INS_RD;
        end else begin
          state_d = S_INS_FIN;
        end
      end
      S_INS_FIN: begin
        mem_o.we          = 1'b1;
        mem_o.waddr       = hit_inc[AW-1:0];
        mem_o.wdata.start = 16'({1'b0, cur_q.start} + HDR17 + sz_q);
        mem_o.wdata.len   = 16'({1'b0, cur_q.len} - sz_q - HDR17);
        mem_o.wdata.free  = 1'b1;
        cur_d.len         = sz_q[15:0];
        cnt_d             = cnt_q + CW'(1);
        state_d           = S_ALLOC_WR;
      end
      S_ALLOC_WR: begin
        mem_o.we         = 1'b1;
        mem_o.waddr      = hit_q[AW-1:0];
        mem_o.wdata      = cur_q;
        mem_o.wdata.free = 1'b0;
        used_d           = used_q + amount;
        res_off_d        = cur_q.start + 16'(HEADER_BYTES);
        state_d          = S_RESP;
      end
      S_PREV_RD: begin
        used_d = (used_q >= amount) ? used_q - amount : 17'd0;
        if (hit_q == '0) begin
          prev_d.free = 1'b0;
          if (has_next) begin
            state_d = S_NEXT_RD;
          end else begin
            next_d.free = 1'b0;
            state_d     = S_MERGE;
          end
        end else begin
          mem_o.raddr = hit_q[AW-1:0] - AW'(1);
          state_d     = S_PREV_CK;
        end
      end
      S_PREV_CK: begin
        prev_d = mem_rdata_i;
        if (has_next) begin
          state_d = S_NEXT_RD;
        end else begin
          next_d.free = 1'b0;
          state_d     = S_MERGE;
        end
      end
      S_NEXT_RD: begin
        mem_o.raddr = hit_inc[AW-1:0];
        state_d     = S_NEXT_CK;
      end
      S_NEXT_CK: begin
        next_d  = mem_rdata_i;
        state_d = S_MERGE;
      end
      S_MERGE: begin
        mem_o.we         = 1'b1;
        mem_o.wdata.free = 1'b1;
        state_d          = S_RM_CHK;
        if (prev_q.free) begin
          mem_o.waddr       = hit_q[AW-1:0] - AW'(1);
          mem_o.wdata.start = prev_q.start;
          k_d               = hit_q;
          if (next_q.free) begin
            mem_o.wdata.len = prev_q.len + 16'(HEADER_BYTES) + cur_q.len
                              + 16'(HEADER_BYTES) + next_q.len;
            rm_n_d          = 2'd2;
          end else begin
            mem_o.wdata.len = prev_q.len + 16'(HEADER_BYTES) + cur_q.len;
            rm_n_d          = 2'd1;
          end
        end else begin
          mem_o.waddr       = hit_q[AW-1:0];
          mem_o.wdata.start = cur_q.start;
          if (next_q.free) begin
            mem_o.wdata.len = cur_q.len + 16'(HEADER_BYTES) + next_q.len;
            k_d             = hit_inc;
            rm_n_d          = 2'd1;
          end else begin
            mem_o.wdata.len = cur_q.len;
            state_d         = S_RESP;
          end
        end
      end
      S_RM_CHK: begin
        if (k_plus_n < {1'b0, cnt_q}) begin
          state_d = S_RM_RD;
        end else begin
          cnt_d   = cnt_q - CW'(rm_n_q);
          state_d = S_RESP;
        end
      end
      S_RM_RD: begin
        mem_o.raddr = k_plus_n[AW-1:0];
        state_d     = S_RM_WR;
      end
      S_RM_WR: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = k_q[AW-1:0];
        mem_o.wdata = mem_rdata_i;
        k_d         = k_inc;
        state_d     = S_RM_CHK;
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d          = 1'b1;
          out_d.payload_offset = res_off_q;
          out_d.status         = res_st_q;
          out_d.used_bytes     = used_q;
          state_d              = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      cnt_q       <= CW'(1);
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q     <= out_d;
    op_q      <= op_d;
    sz_q      <= sz_d;
    off_q     <= off_d;
    k_q       <= k_d;
    hit_q     <= hit_d;
    cur_q     <= cur_d;
    prev_q    <= prev_d;
    next_q    <= next_d;
    rm_n_q    <= rm_n_d;
    res_off_q <= res_off_d;
    res_st_q  <= res_st_d;
  end

`include "first_fit_block_allocator_assert.svh"

  `FFA_ASSERT_ALWAYS(a_cnt_range, clk_i, rst_ni, (cnt_q != '0) && (cnt_q <= MAX_CNT))
  `FFA_ASSERT_IMPL(a_wr_in_table, clk_i, rst_ni, mem_o.we && (state_q != S_INIT),
                   {1'b0, mem_o.waddr} <= {1'b0, cnt_q})
  `FFA_ASSERT_IMPL(a_out_from_resp, clk_i, rst_ni, $rose(out_valid_q), $past(state_q) == S_RESP)

endmodule
`default_nettype wire

// ===== design/first_fit_block_allocator.sv =====
// top level: first-fit heap allocator, sequencer plus block table memory
// alloc: scans table entries in order, and shifts later entries up by one on a split
// free: scans entries to the match, reads the neighbors that exist, merges and shifts later entries down
// the speed of scans and shifts is set by the single read port of the block table
// one item in flight; the next is accepted while a result waits in the output register
// reset: the init state writes the initial free block into entry 0 before the first item is taken
`default_nettype none
module first_fit_block_allocator (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_ready_o,
  input  ffa_pkg::ffa_req_t in_data_i,
  output logic              out_valid_o,
  input  wire               out_ready_i,
  output ffa_pkg::ffa_rsp_t out_data_o
);
  import ffa_pkg::*;

  ffa_mem_req_t mem_req;
  ffa_entry_t   mem_rdata;

  ffa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .mem_o       (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  ffa_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

endmodule
`default_nettype wire
